/* rtl/hdlcrx_pkg.sv */
// ----------------------------------------------------------------------------
// hdlcrx_pkg: shared types and constants for the HDLC frame receiver
// Item structs, operation codes, buffer capacity and CRC constants.
// ----------------------------------------------------------------------------
package hdlcrx_pkg;

  // Frame buffer capacity in bytes (valid range 16..4095)
  localparam int unsigned MAX_BYTES = 2048;
  // Byte counter must be able to hold MAX_BYTES itself
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);

  localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
  localparam logic [4:0]  INFO_OFFSET = 5'd9;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  // Operation codes
  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_DISCARD = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } hdlcrx_in_t;

  typedef struct packed {
    logic        frame_complete;
    logic        crc_ok;
    logic [3:0]  format_type;
    logic [10:0] frame_length;
    logic [2:0]  dest_addr_len;
    logic [2:0]  src_addr_len;
    logic [7:0]  control_byte;
    logic [15:0] header_check;
    logic [4:0]  info_start;
    logic [10:0] info_length;
    logic [11:0] byte_count;
    logic        addr_error;
  } hdlcrx_out_t;

endpackage

/* rtl/hdlcrx_crc_step.sv */
// ----------------------------------------------------------------------------
// hdlcrx_crc_step: one-byte CRC-16/X.25 update
// Reflected polynomial, LSB first; eight shift steps unrolled.
// ----------------------------------------------------------------------------
module hdlcrx_crc_step
  import hdlcrx_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

/* rtl/hdlc_frame_receiver.sv */
// ----------------------------------------------------------------------------
// hdlc_frame_receiver: byte-serial DLMS-style HDLC frame receiver
// Latency: the result item for an input item is valid the cycle after accept.
// Throughput: one item per cycle unless out_ready stalls; combinational update.
// Reset: rst_n (sync, active low) clears frame state, CRC to 0xFFFF, no output.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver
  import hdlcrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  hdlcrx_in_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output hdlcrx_out_t out_data
);

  // Frame state. Every accepted item updates it and produces one result item
  // that reflects the state after the update.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0]      fmt_r, fmt_nxt;          // frame format word
  logic [2:0]       dest_len_r, dest_len_nxt;
  logic [2:0]       src_len_r, src_len_nxt;
  logic             addr_fault_r, addr_fault_nxt;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic [15:0]      hcs_r, hcs_nxt;
  logic [7:0]       dly0_r, dly0_nxt;        // three-byte delay line: the last
  logic [7:0]       dly1_r, dly1_nxt;        // two bytes may be FCS, so a byte
  logic [7:0]       dly2_r, dly2_nxt;        // enters the CRC three bytes late
  logic [15:0]      crc_r, crc_nxt;

  logic             out_valid_r, out_valid_nxt;
  hdlcrx_out_t      out_data_r, out_data_nxt;

  logic             accept;
  logic             store;
  logic [15:0]      crc_upd;
  logic [2:0]       pos;
  logic [CNT_W-1:0] base;

  // Output register parts the two sides: a new item is taken whenever the
  // held result leaves in the same cycle or none is held.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  hdlcrx_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (dly2_r),
    .crc_out (crc_upd)
  );

  // A byte is stored unless: buffer full, hunting for the opening flag, or
  // a repeated flag right after the opening one.
  always_comb begin
    store = (in_data.operation == OP_ADD) && (count_r < CNT_W'(MAX_BYTES));
    if (count_r == '0 && in_data.rx_byte != FLAG_BYTE) begin
      store = 1'b0;
    end
    if (count_r == CNT_W'(1) && in_data.rx_byte == FLAG_BYTE) begin
      store = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Next frame state
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt      = count_r;
    fmt_nxt        = fmt_r;
    dest_len_nxt   = dest_len_r;
    src_len_nxt    = src_len_r;
    addr_fault_nxt = addr_fault_r;
    ctrl_nxt       = ctrl_r;
    hcs_nxt        = hcs_r;
    dly0_nxt       = dly0_r;
    dly1_nxt       = dly1_r;
    dly2_nxt       = dly2_r;
    crc_nxt        = crc_r;
    pos            = '0;
    base           = CNT_W'(3) + CNT_W'(dest_len_r) + CNT_W'(src_len_r);

    if (in_data.operation == OP_DISCARD) begin
      count_nxt      = '0;
      fmt_nxt        = '0;
      dest_len_nxt   = '0;
      src_len_nxt    = '0;
      addr_fault_nxt = 1'b0;
      ctrl_nxt       = '0;
      hcs_nxt        = '0;
      dly0_nxt       = '0;
      dly1_nxt       = '0;
      dly2_nxt       = '0;
      crc_nxt        = CRC_INIT;
    end else if (store) begin
      // oldest delayed byte enters the CRC once four bytes are stored
      if (count_r >= CNT_W'(4)) begin
        crc_nxt = crc_upd;
      end
      dly2_nxt  = dly1_r;
      dly1_nxt  = dly0_r;
      dly0_nxt  = in_data.rx_byte;
      count_nxt = count_r + CNT_W'(1);

      if (count_r == CNT_W'(1)) begin
        fmt_nxt = {in_data.rx_byte, fmt_r[7:0]};
      end else if (count_r == CNT_W'(2)) begin
        fmt_nxt = {fmt_r[15:8], in_data.rx_byte};
      end else if (count_r >= CNT_W'(3)) begin
        if (dest_len_r == '0) begin
          // address byte position never exceeds three while still open
          pos = 3'(count_r - CNT_W'(3));
          if (in_data.rx_byte[0]) begin
            dest_len_nxt = pos + 3'd1;
          end else if (pos >= 3'd3) begin
            dest_len_nxt   = 3'd4;
            addr_fault_nxt = 1'b1;
          end
        end else if (src_len_r == '0) begin
          pos = 3'(count_r - CNT_W'(3) - CNT_W'(dest_len_r));
          if (in_data.rx_byte[0]) begin
            src_len_nxt = pos + 3'd1;
          end else if (pos >= 3'd3) begin
            src_len_nxt    = 3'd4;
            addr_fault_nxt = 1'b1;
          end
        end else begin
          if (count_r == base) begin
            ctrl_nxt = in_data.rx_byte;
          end else if (count_r == base + CNT_W'(1)) begin
            hcs_nxt = {in_data.rx_byte, hcs_r[7:0]};
          end else if (count_r == base + CNT_W'(2)) begin
            hcs_nxt = {hcs_r[15:8], in_data.rx_byte};
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result fields, taken from the updated state
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [12:0] cnt_ext;
    logic [12:0] flen_ext;
    logic [11:0] start_ext;

    cnt_ext   = 13'(count_nxt);
    flen_ext  = {2'b00, fmt_nxt[10:0]};
    start_ext = '0;

    out_data_nxt.format_type   = fmt_nxt[15:12];
    out_data_nxt.frame_length  = fmt_nxt[10:0];
    out_data_nxt.dest_addr_len = dest_len_nxt;
    out_data_nxt.src_addr_len  = src_len_nxt;
    out_data_nxt.control_byte  = ctrl_nxt;
    out_data_nxt.header_check  = hcs_nxt;
    out_data_nxt.byte_count    = 12'(count_nxt);
    out_data_nxt.addr_error    = addr_fault_nxt;

    // complete on length reached, or on a full buffer
    if (cnt_ext >= 13'(MAX_BYTES)) begin
      out_data_nxt.frame_complete = 1'b1;
    end else if (cnt_ext < 13'd3) begin
      out_data_nxt.frame_complete = 1'b0;
    end else begin
      out_data_nxt.frame_complete = cnt_ext >= (flen_ext + 13'd2);
    end

    // FCS is little-endian: older delayed byte is the low byte
    out_data_nxt.crc_ok = (cnt_ext >= 13'd4) && ((~crc_nxt) == {dly1_nxt, dly2_nxt});

    // info bounds known only once both addresses are closed
    out_data_nxt.info_start  = '0;
    out_data_nxt.info_length = '0;
    if (dest_len_nxt != '0 && src_len_nxt != '0) begin
      out_data_nxt.info_start = INFO_OFFSET + 5'(dest_len_nxt) + 5'(src_len_nxt);
      start_ext = 12'(out_data_nxt.info_start) + 12'd1;
      if (12'(fmt_nxt[10:0]) > start_ext) begin
        out_data_nxt.info_length = 11'(12'(fmt_nxt[10:0]) - start_ext);
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      fmt_r        <= '0;
      dest_len_r   <= '0;
      src_len_r    <= '0;
      addr_fault_r <= 1'b0;
      ctrl_r       <= '0;
      hcs_r        <= '0;
      dly0_r       <= '0;
      dly1_r       <= '0;
      dly2_r       <= '0;
      crc_r        <= CRC_INIT;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r      <= count_nxt;
        fmt_r        <= fmt_nxt;
        dest_len_r   <= dest_len_nxt;
        src_len_r    <= src_len_nxt;
        addr_fault_r <= addr_fault_nxt;
        ctrl_r       <= ctrl_nxt;
        hcs_r        <= hcs_nxt;
        dly0_r       <= dly0_nxt;
        dly1_r       <= dly1_nxt;
        dly2_r       <= dly2_nxt;
        crc_r        <= crc_nxt;
      end
    end
  end

  // result payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/hdlcrx_checker.sv */
// ----------------------------------------------------------------------------
// hdlcrx_checker: port-level checks for the HDLC frame receiver
// Watches both channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module hdlcrx_checker
  import hdlcrx_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input hdlcrx_in_t  in_data,
  input logic        out_valid,
  input logic        out_ready,
  input hdlcrx_out_t out_data
);

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // every accepted item yields a result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted item");

  // a discard item leaves a cleared frame
  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_DISCARD |=>
      out_data.byte_count == '0 && !out_data.crc_ok && out_data.dest_addr_len == '0)
    else $error("discard did not clear the frame");

  // full buffer always reports completion and never overfills
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.byte_count <= 12'(MAX_BYTES) &&
      (out_data.byte_count != 12'(MAX_BYTES) || out_data.frame_complete))
    else $error("byte count beyond capacity or full frame not complete");

  // info start is known exactly when both address lengths are
  a_info: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.info_start != '0) ==
      (out_data.dest_addr_len != '0 && out_data.src_addr_len != '0))
    else $error("info start inconsistent with address lengths");

endmodule

bind hdlc_frame_receiver hdlcrx_checker u_hdlcrx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for hdlc_frame_receiver
// Streams HDLC frames and line noise into the receiver and checks every
// result item against a cycle-free predictor. Both channels idle at random,
// and the result side stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import hdlcrx_pkg::*;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT ports
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  hdlcrx_in_t  in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  hdlcrx_out_t out_data;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hdlc_frame_receiver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // --------------------------------------------------------------------------
  // Pending input items. drain_first holds the item back until every result
  // already owed by the DUT has come out.
  // --------------------------------------------------------------------------
  typedef struct {
    hdlcrx_in_t item;
    bit         drain_first;
  } pend_t;

  pend_t       pending_q[$];
  hdlcrx_out_t expected_q[$];

  int unsigned accepted_n = 0;  // items taken by the DUT (NBA, driver only)
  int unsigned checked_n  = 0;  // result items seen (NBA, monitor only)
  int unsigned fail_n     = 0;
  int unsigned real_n     = 0;  // stimulus items that count toward the total
  int unsigned frames_n   = 0;
  int unsigned good_fcs_n = 0;  // completed frames with a matching FCS
  bit          tally_on   = 1'b0;

  int send_gap   = 0;
  int stall_left = 0;
  int calm_left  = 0;  // > 0: a stretch with no idling on either side
  int hold_left  = 0;  // the one long receiver hold-off
  bit hold_done  = 1'b0;

  // --------------------------------------------------------------------------
  // Receiver shadow state
  // --------------------------------------------------------------------------
  int unsigned n_stored;
  logic [15:0] fmt_word;
  int unsigned dst_bytes;
  int unsigned src_bytes;
  logic        addr_bad;
  logic [7:0]  ctrl_q;
  logic [15:0] hcs_q;
  logic [7:0]  tail [3];   // tail[0] newest; tail[2] is next into the CRC
  logic [15:0] crc_acc;

  // CRC-16/X.25, reflected, one byte
  function automatic logic [15:0] x25_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_frame();
    n_stored  = 0;
    fmt_word  = '0;
    dst_bytes = 0;
    src_bytes = 0;
    addr_bad  = 1'b0;
    ctrl_q    = '0;
    hcs_q     = '0;
    tail[0]   = '0;
    tail[1]   = '0;
    tail[2]   = '0;
    crc_acc   = CRC_INIT;
  endfunction

  // Advance the shadow state by one item and return the result item it owes.
  function automatic hdlcrx_out_t rx_predict(hdlcrx_in_t it);
    hdlcrx_out_t r;
    logic [7:0]  b;
    int unsigned i, pos, base, flen, start, ilen;
    bit          take;
    b = it.rx_byte;
    if (it.operation == OP_DISCARD) begin
      clear_frame();
    end else if (n_stored < MAX_BYTES) begin
      // hunt for the opening flag; a flag right after it is a repeat
      take = !(n_stored == 0 && b != FLAG_BYTE) && !(n_stored == 1 && b == FLAG_BYTE);
      if (take) begin
        i = n_stored;
        // CRC lags three bytes: FCS pair and closing flag stay out of it
        if (i >= 4) crc_acc = x25_update(crc_acc, tail[2]);
        tail[2] = tail[1];
        tail[1] = tail[0];
        tail[0] = b;
        if (i == 1) begin
          fmt_word[15:8] = b;
        end else if (i == 2) begin
          fmt_word[7:0] = b;
        end else if (i >= 3) begin
          if (dst_bytes == 0) begin
            pos = i - 3;
            if (b[0]) begin
              dst_bytes = pos + 1;
            end else if (pos >= 3) begin
              dst_bytes = 4;
              addr_bad  = 1'b1;
            end
          end else if (src_bytes == 0) begin
            pos = i - 3 - dst_bytes;
            if (b[0]) begin
              src_bytes = pos + 1;
            end else if (pos >= 3) begin
              src_bytes = 4;
              addr_bad  = 1'b1;
            end
          end else begin
            base = 3 + dst_bytes + src_bytes;
            if (i == base) ctrl_q = b;
            else if (i == base + 1) hcs_q[15:8] = b;
            else if (i == base + 2) hcs_q[7:0] = b;
          end
        end
        n_stored = i + 1;
      end
    end

    flen  = fmt_word[10:0];
    start = 0;
    ilen  = 0;
    if (dst_bytes != 0 && src_bytes != 0) begin
      start = INFO_OFFSET + dst_bytes + src_bytes;
      ilen  = (flen > start + 1) ? flen - start - 1 : 0;
    end
    r.frame_complete = (n_stored >= MAX_BYTES) || (n_stored >= 3 && n_stored >= flen + 2);
    r.crc_ok         = (n_stored >= 4) && ((~crc_acc) == {tail[1], tail[2]});
    r.format_type    = fmt_word[15:12];
    r.frame_length   = fmt_word[10:0];
    r.dest_addr_len  = 3'(dst_bytes);
    r.src_addr_len   = 3'(src_bytes);
    r.control_byte   = ctrl_q;
    r.header_check   = hcs_q;
    r.info_start     = 5'(start);
    r.info_length    = 11'(ilen);
    r.byte_count     = 12'(n_stored);
    r.addr_error     = addr_bad;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_item(logic op, logic [7:0] b, bit drain);
    pend_t p;
    p.item.operation = op;
    p.item.rx_byte   = b;
    p.drain_first    = drain;
    pending_q = {pending_q, p};
    if (tally_on) real_n++;
  endtask

  // One frame: flag(s), format, addresses, control, HCS, info, FCS, flag,
  // then a discard to rearm the receiver. Some frames get a bad length, bad
  // FCS, over-long address, trailing junk or are cut short.
  task automatic queue_frame(int unsigned info_n, bit drain, bit jumbo);
    logic [7:0]  body[$];
    logic [7:0]  line[$];
    logic [7:0]  rnd;
    logic [15:0] crc;
    logic [10:0] flen;
    logic [3:0]  ftype;
    int unsigned d_n, s_n, lim;
    bit          d_bad, s_bad, lsb;
    d_bad = ($urandom_range(0, 11) == 0);
    s_bad = ($urandom_range(0, 11) == 0);
    d_n   = d_bad ? 4 : $urandom_range(1, 4);
    s_n   = s_bad ? 4 : $urandom_range(1, 4);
    ftype = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'hA;
    body = {body, 8'h00};  // format word, filled in once the size is known
    body = {body, 8'h00};
    for (int k = 0; k < d_n; k++) begin
      rnd  = $urandom;
      lsb  = (k == d_n - 1) && !d_bad;
      body = {body, {rnd[7:1], lsb}};
    end
    for (int k = 0; k < s_n; k++) begin
      rnd  = $urandom;
      lsb  = (k == s_n - 1) && !s_bad;
      body = {body, {rnd[7:1], lsb}};
    end
    repeat (3) begin  // control + HCS
      rnd  = $urandom;
      body = {body, rnd};
    end
    repeat (info_n) begin
      rnd  = $urandom;
      body = {body, rnd};
    end
    if (jumbo) flen = 11'h7FF;
    else if ($urandom_range(0, 9) == 0) flen = 11'($urandom);
    else flen = 11'(body.size() + 2);
    body[0] = {ftype, 1'b0, flen[10:8]};
    body[1] = flen[7:0];

    crc = CRC_INIT;
    foreach (body[k]) crc = x25_update(crc, body[k]);
    crc = ~crc;
    if ($urandom_range(0, 9) == 0) crc = crc ^ (16'h0001 << $urandom_range(0, 15));

    line = {line, FLAG_BYTE};
    if ($urandom_range(0, 3) == 0) line = {line, FLAG_BYTE};
    foreach (body[k]) line = {line, body[k]};
    line = {line, crc[7:0]};
    line = {line, crc[15:8]};
    line = {line, FLAG_BYTE};
    if (jumbo || $urandom_range(0, 4) == 0) begin
      repeat (jumbo ? 8 : $urandom_range(1, 3)) begin
        rnd  = $urandom;
        line = {line, rnd};
      end
    end

    lim = line.size();
    if (!jumbo && $urandom_range(0, 6) == 0) lim = $urandom_range(1, line.size() - 1);
    for (int k = 0; k < lim; k++) queue_item(OP_ADD, line[k], drain && k == 0);
    rnd = $urandom;
    queue_item(OP_DISCARD, rnd, 1'b0);
    frames_n++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers pending items, predicts on every accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      send_gap   <= 0;
      accepted_n <= 0;
      clear_frame();
    end else begin
      if (in_valid && in_ready) begin
        expected_q = {expected_q, rx_predict(in_data)};
        accepted_n <= accepted_n + 1;
      end
      // free to change the offer only when nothing is held or it just went
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain_first &&
                       (in_valid || accepted_n != checked_n))) begin
          in_valid <= 1'b1;
          in_data  <= pending_q[0].item;
          void'(pending_q.pop_front());
          send_gap <= (calm_left > 0) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks result items against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    hdlcrx_out_t want;
    string       bad;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      checked_n  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        checked_n <= checked_n + 1;
        if (expected_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("result %0d: item %h arrived with nothing pending", checked_n, out_data);
        end else begin
          want = expected_q.pop_front();
          bad  = "";
          if (out_data.frame_complete !== want.frame_complete)
            bad = {bad, $sformatf(" frame_complete %0d/%0d", want.frame_complete,
                                  out_data.frame_complete)};
          if (out_data.crc_ok !== want.crc_ok)
            bad = {bad, $sformatf(" crc_ok %0d/%0d", want.crc_ok, out_data.crc_ok)};
          if (out_data.format_type !== want.format_type)
            bad = {bad, $sformatf(" format_type %h/%h", want.format_type,
                                  out_data.format_type)};
          if (out_data.frame_length !== want.frame_length)
            bad = {bad, $sformatf(" frame_length %0d/%0d", want.frame_length,
                                  out_data.frame_length)};
          if (out_data.dest_addr_len !== want.dest_addr_len)
            bad = {bad, $sformatf(" dest_addr_len %0d/%0d", want.dest_addr_len,
                                  out_data.dest_addr_len)};
          if (out_data.src_addr_len !== want.src_addr_len)
            bad = {bad, $sformatf(" src_addr_len %0d/%0d", want.src_addr_len,
                                  out_data.src_addr_len)};
          if (out_data.control_byte !== want.control_byte)
            bad = {bad, $sformatf(" control_byte %h/%h", want.control_byte,
                                  out_data.control_byte)};
          if (out_data.header_check !== want.header_check)
            bad = {bad, $sformatf(" header_check %h/%h", want.header_check,
                                  out_data.header_check)};
          if (out_data.info_start !== want.info_start)
            bad = {bad, $sformatf(" info_start %0d/%0d", want.info_start,
                                  out_data.info_start)};
          if (out_data.info_length !== want.info_length)
            bad = {bad, $sformatf(" info_length %0d/%0d", want.info_length,
                                  out_data.info_length)};
          if (out_data.byte_count !== want.byte_count)
            bad = {bad, $sformatf(" byte_count %0d/%0d", want.byte_count,
                                  out_data.byte_count)};
          if (out_data.addr_error !== want.addr_error)
            bad = {bad, $sformatf(" addr_error %0d/%0d", want.addr_error,
                                  out_data.addr_error)};
          if (bad != "") begin
            fail_n++;
            if (fail_n <= 10)
              $display("result %0d mismatch (expected/actual):%s", checked_n, bad);
          end
          if (want.frame_complete && want.crc_ok) good_fcs_n++;
        end
      end
      // long hold-off wins; else stall at random after each non-calm result
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready && calm_left == 0) stall_left <= pick_gap();
      end
    end
  end

  // One long receiver hold-off, a little way into the random traffic, so the
  // DUT backs up and drops in_ready while the driver keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_n >= 120) begin
      hold_left <= 250;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Stretches with no idling at all on either side
  always @(posedge clk) begin
    if (!rst_n) calm_left <= 0;
    else if (calm_left > 0) calm_left <= calm_left - 1;
    else if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(40, 160);
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run
    logic [7:0]  rnd;
    int unsigned pick, info_n;

    // Directed: hunting, discard while idle, repeated flag, all-ones format,
    // over-long addresses on both sides, then a frame that is complete at
    // three bytes and far too short for a valid FCS.
    queue_item(OP_ADD, 8'h00, 1'b0);
    queue_item(OP_ADD, 8'hFF, 1'b0);
    queue_item(OP_DISCARD, FLAG_BYTE, 1'b0);
    queue_item(OP_ADD, FLAG_BYTE, 1'b0);
    queue_item(OP_ADD, FLAG_BYTE, 1'b0);
    queue_item(OP_ADD, 8'hFF, 1'b0);
    queue_item(OP_ADD, 8'hFF, 1'b0);
    repeat (4) queue_item(OP_ADD, 8'h00, 1'b0);
    repeat (4) queue_item(OP_ADD, 8'hFE, 1'b0);
    queue_item(OP_ADD, 8'hFF, 1'b0);
    queue_item(OP_ADD, 8'h00, 1'b0);
    queue_item(OP_ADD, 8'hFF, 1'b0);
    queue_item(OP_DISCARD, 8'hFF, 1'b0);
    queue_item(OP_ADD, FLAG_BYTE, 1'b0);
    queue_item(OP_ADD, 8'h00, 1'b0);
    queue_item(OP_ADD, 8'h00, 1'b0);
    queue_item(OP_ADD, FLAG_BYTE, 1'b0);
    queue_item(OP_DISCARD, 8'h00, 1'b0);

    // Random: mostly well-formed frames, some noise and stray discards.
    tally_on = 1'b1;
    while (real_n < 400) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // noise while hunting; kept off the flag so it stays ignored
        tally_on = 1'b0;
        repeat ($urandom_range(1, 4)) begin
          rnd = $urandom;
          if (rnd == FLAG_BYTE) rnd = 8'h7F;
          queue_item(OP_ADD, rnd, 1'b0);
        end
        tally_on = 1'b1;
      end else if (pick < 14) begin
        rnd = $urandom;
        queue_item(OP_DISCARD, rnd, 1'b0);
      end else begin
        info_n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        queue_frame(info_n, frames_n == 2 || pick < 22, 1'b0);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (accepted_n != checked_n) @(posedge clk);
    repeat (10) @(posedge clk);

    if (expected_q.size() != 0) begin
      fail_n += expected_q.size();
      $display("%0d result items never arrived", expected_q.size());
    end
    $display("run: %0d items in %0d frames, with noise, discards and malformed frames",
             accepted_n, frames_n);
    $display("run: %0d results checked, %0d frames closed with a good FCS, %0d failures",
             checked_n, good_fcs_n, fail_n);
    if (fail_n == 0) begin
      $display("[hdlc_frame_receiver] OK");
    end else begin
      $display("[hdlc_frame_receiver] ERROR");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[hdlc_frame_receiver] ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/hdlcrx_pkg.sv
rtl/hdlcrx_crc_step.sv
rtl/hdlc_frame_receiver.sv
rtl/hdlcrx_checker.sv
bench/tb.sv
